FILE: hdl/assert_macros.svh
// Assertion macros used by the mipmap downsampler RTL.
// Expects clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define MBD_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be true at a clock edge out of reset
`define MBD_ASSERT_NEVER(name, cond, msg) \
	`MBD_ASSERT(name, !(cond), msg)

`endif

FILE: hdl/mbd_pkg.sv
// Package for the mipmap 2x2 box downsampler: sizes, pixel and command types.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps

package mbd_pkg;

	localparam int MAX_WIDTH_LOG2    = 12;
	localparam int HEIGHT_LOG2_LIMIT = 12;
	localparam int LOG2_W            = 4;
	localparam int POS_W             = MAX_WIDTH_LOG2;
	localparam int ROW_W             = HEIGHT_LOG2_LIMIT;
	localparam int LINE_AW           = MAX_WIDTH_LOG2 - 1;
	localparam int LINE_DEPTH        = 1 << LINE_AW;
	localparam int NUM_CHAN          = 4;
	localparam int CMDQ_DEPTH        = 4;
	localparam int CMDQ_AW           = 2;
	localparam int OUTQ_DEPTH        = 4;
	localparam int OUTQ_AW           = 2;
	localparam int REG_IDX_W         = 2;

	localparam logic [REG_IDX_W-1:0] REG_WIDTH_LOG2  = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT_LOG2 = REG_IDX_W'(1);

	typedef logic [NUM_CHAN-1:0][7:0] pix_t;
	typedef logic [NUM_CHAN-1:0][8:0] psum_t;

	typedef enum logic [1:0] {
		OP_STORE,
		OP_EMIT_DIRECT,
		OP_EMIT_LINE
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [LINE_AW-1:0] addr;
		psum_t              hsum;
		logic               last;
	} cmd_t;

	typedef struct packed {
		pix_t pix;
		logic last;
	} res_t;

endpackage

FILE: hdl/mipmap_box_downsample_rgba_core.sv
// Top level of the RGBA8 2x2 box mipmap downsampler.
// Depends on mbd_pkg, mbd_front, mbd_cmdq and mbd_back.
`timescale 1ns / 1ps

// Accepts one source pixel per clock while full is low, in raster order
// (push/full), and returns the next mip level in raster order (empty/pop),
// one result per 2x2 block, each channel (a+b+c+d+2)>>2, with last_of_level
// on the final pixel. Even rows park horizontal pair sums in a 2048 x 36 line
// store, one access per clock, which the odd rows complete. A result passes
// the command queue, the stage-1 registers and the result queue on its way
// out. The line store needs no clearing after reset. Write width_log2
// (index 0) and height_log2 (index 1) only while the block is idle; a write
// to either restarts the level at pixel zero.
module mipmap_box_downsample_rgba_core import mbd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [LOG2_W-1:0]    wr_data,
	input  logic                 push,
	output logic                 full,
	input  logic [7:0]           red_in,
	input  logic [7:0]           green_in,
	input  logic [7:0]           blue_in,
	input  logic [7:0]           alpha_in,
	output logic                 empty,
	input  logic                 pop,
	output logic [7:0]           red_out,
	output logic [7:0]           green_out,
	output logic [7:0]           blue_out,
	output logic [7:0]           alpha_out,
	output logic                 last_of_level
);

	pix_t pix;
	cmd_t front_cmd, back_cmd;
	logic front_push, cmdq_empty, back_pop;
	res_t res;

	assign pix = {alpha_in, blue_in, green_in, red_in};

	mbd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.push     (push),
		.pix      (pix),
		.cmd_full (full),
		.cmd_push (front_push),
		.cmd      (front_cmd)
	);

	mbd_cmdq u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_push),
		.push_data (front_cmd),
		.full      (full),
		.pop       (back_pop),
		.pop_data  (back_cmd),
		.empty     (cmdq_empty)
	);

	mbd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmdq_empty),
		.cmd       (back_cmd),
		.cmd_pop   (back_pop),
		.res       (res),
		.res_empty (empty),
		.res_pop   (pop)
	);

	assign red_out       = res.pix[0];
	assign green_out     = res.pix[1];
	assign blue_out      = res.pix[2];
	assign alpha_out     = res.pix[3];
	assign last_of_level = res.last;

endmodule

FILE: hdl/mbd_front.sv
// Front end: config registers, raster position, horizontal pairing, command issue.
// Depends on mbd_pkg.
`timescale 1ns / 1ps

module mbd_front import mbd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [LOG2_W-1:0]    wr_data,
	input  logic                 push,
	input  pix_t                 pix,
	input  logic                 cmd_full,
	output logic                 cmd_push,
	output cmd_t                 cmd
);

	logic [LOG2_W-1:0] width_log2_q, height_log2_q;
	logic [LOG2_W-1:0] wl, hl;
	logic [POS_W-1:0]  x_q, wmask;
	logic [ROW_W-1:0]  y_q, hmask;
	logic [POS_W:0]    wone;
	logic [ROW_W:0]    hone;
	pix_t              held_q;
	logic              accept, have_pair, narrow, row_end, level_end;

	assign wl = (width_log2_q > LOG2_W'(MAX_WIDTH_LOG2)) ? LOG2_W'(MAX_WIDTH_LOG2)
		: width_log2_q;
	assign hl = (height_log2_q > LOG2_W'(HEIGHT_LOG2_LIMIT)) ? LOG2_W'(HEIGHT_LOG2_LIMIT)
		: height_log2_q;
	assign wone  = (POS_W+1)'(1) << wl;
	assign hone  = (ROW_W+1)'(1) << hl;
	assign wmask = POS_W'(wone - (POS_W+1)'(1));
	assign hmask = ROW_W'(hone - (ROW_W+1)'(1));

	assign narrow    = (wl == '0);
	assign accept    = push && !cmd_full;
	assign have_pair = narrow || x_q[0];
	assign row_end   = (x_q == wmask);
	assign level_end = row_end && (y_q == hmask);
	assign cmd_push  = accept && have_pair;

	always_comb begin
		for (int k = 0; k < NUM_CHAN; k++) begin
			if (narrow) begin
				cmd.hsum[k] = {pix[k], 1'b0};
			end else begin
				cmd.hsum[k] = {1'b0, held_q[k]} + {1'b0, pix[k]};
			end
		end
		if (hl == '0) begin
			cmd.op = OP_EMIT_DIRECT;
		end else if (!y_q[0]) begin
			cmd.op = OP_STORE;
		end else begin
			cmd.op = OP_EMIT_LINE;
		end
		cmd.addr = narrow ? '0 : x_q[POS_W-1:1];
		cmd.last = level_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_log2_q  <= '0;
			height_log2_q <= '0;
			x_q           <= '0;
			y_q           <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_WIDTH_LOG2: begin
					width_log2_q <= wr_data;
					x_q          <= '0;
					y_q          <= '0;
				end
				REG_HEIGHT_LOG2: begin
					height_log2_q <= wr_data;
					x_q           <= '0;
					y_q           <= '0;
				end
				default: ;
			endcase
		end else if (accept) begin
			if (row_end) begin
				x_q <= '0;
				y_q <= (y_q == hmask) ? '0 : y_q + ROW_W'(1);
			end else begin
				x_q <= x_q + POS_W'(1);
			end
		end
	end

	// even-column pixel waits for its partner
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (accept && !narrow && !x_q[0]) begin
			held_q <= pix;
		end
	end

endmodule

FILE: hdl/mbd_cmdq.sv
// Short command queue between front and back end.
// Depends on mbd_pkg.
`timescale 1ns / 1ps

module mbd_cmdq import mbd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output cmd_t pop_data,
	output logic empty
);

	cmd_t               slot_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CMDQ_AW:0]   count_q;
	logic               do_push, do_pop;

	assign full     = (count_q == (CMDQ_AW+1)'(CMDQ_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + CMDQ_AW'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + CMDQ_AW'(1);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (CMDQ_AW+1)'(1);
				2'b01:   count_q <= count_q - (CMDQ_AW+1)'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_data;
	end

endmodule

FILE: hdl/mbd_back.sv
// Back end: line store of pair sums, vertical completion, rounding, result queue.
// Depends on mbd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mbd_back import mbd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_empty,
	input  cmd_t cmd,
	output logic cmd_pop,
	output res_t res,
	output logic res_empty,
	input  logic res_pop
);

	psum_t              line_mem_q [LINE_DEPTH];
	psum_t              rd_s1;
	cmd_t               cmd_s1;
	logic               valid_s1;
	res_t               outq_q [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [OUTQ_AW:0]   out_cnt_q;
	logic [OUTQ_AW:0]   committed;
	logic               is_emit, do_pop;
	res_t               res_s1;
	logic [9:0]         sum;
	logic [8:0]         other;

	// results in flight are counted against queue room
	assign committed = out_cnt_q + (OUTQ_AW+1)'(valid_s1);
	assign cmd_pop   = !cmd_empty && (committed < (OUTQ_AW+1)'(OUTQ_DEPTH));
	assign is_emit   = (cmd.op != OP_STORE);
	assign res_empty = (out_cnt_q == '0);
	assign do_pop    = res_pop && !res_empty;
	assign res       = outq_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.op == OP_STORE) begin
			line_mem_q[cmd.addr] <= cmd.hsum;
		end
		if (cmd_pop && cmd.op == OP_EMIT_LINE) begin
			rd_s1 <= line_mem_q[cmd.addr];
		end
		if (cmd_pop) begin
			cmd_s1 <= cmd;
		end
	end

	always_comb begin
		sum   = '0;
		other = '0;
		for (int k = 0; k < NUM_CHAN; k++) begin
			other = (cmd_s1.op == OP_EMIT_DIRECT) ? cmd_s1.hsum[k] : rd_s1[k];
			sum   = {1'b0, other} + {1'b0, cmd_s1.hsum[k]} + 10'd2;
			res_s1.pix[k] = sum[9:2];
		end
		res_s1.last = cmd_s1.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			valid_s1 <= cmd_pop && is_emit;
			if (valid_s1) wr_ptr_q <= wr_ptr_q + OUTQ_AW'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + OUTQ_AW'(1);
			case ({valid_s1, do_pop})
				2'b10:   out_cnt_q <= out_cnt_q + (OUTQ_AW+1)'(1);
				2'b01:   out_cnt_q <= out_cnt_q - (OUTQ_AW+1)'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) outq_q[wr_ptr_q] <= res_s1;
	end

	`MBD_ASSERT(a_outq_room, valid_s1 |-> out_cnt_q < (OUTQ_AW+1)'(OUTQ_DEPTH), "result queue overrun")
	`MBD_ASSERT(a_s1_from_pop, valid_s1 |-> $past(cmd_pop), "result without command")
	`MBD_ASSERT_NEVER(a_spurious_result, $past(res_empty && !valid_s1) && !res_empty, "result from nowhere")

endmodule
